@@ rtl/core/pdl_pkg.sv @@
package pdl_pkg;

  localparam int unsigned DataW   = 32;  // Q format word
  localparam int unsigned SqW     = 64;  // sum of three squares
  localparam int unsigned RootW   = 32;  // floor sqrt of SqW bits
  localparam int unsigned NumW    = 62;  // |component| * 31-bit limit
  localparam int unsigned QuotW   = 31;  // scaled component, below a 31-bit limit
  localparam int unsigned CfgIdxW = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPosGain    = 4'd0,
    CfgVelGain    = 4'd1,
    CfgForceLimit = 4'd2,
    CfgRadius     = 4'd3,
    CfgEnable     = 4'd4,
    CfgHomeX      = 4'd5,
    CfgHomeY      = 4'd6,
    CfgHomeZ      = 4'd7
  } pdl_cfg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] pos_x;
    logic signed [DataW-1:0] pos_y;
    logic signed [DataW-1:0] pos_z;
    logic signed [DataW-1:0] vel_x;
    logic signed [DataW-1:0] vel_y;
    logic signed [DataW-1:0] vel_z;
    logic signed [DataW-1:0] target_x;
    logic signed [DataW-1:0] target_y;
    logic signed [DataW-1:0] target_z;
  } pdl_in_t;

  typedef struct packed {
    logic signed [DataW-1:0] force_x;
    logic signed [DataW-1:0] force_y;
    logic signed [DataW-1:0] force_z;
    logic                    in_position;
    logic                    force_clipped;
    logic                    target_clipped;
  } pdl_out_t;

  function automatic logic signed [65:0] sx66(input logic [DataW-1:0] v);
    return {{(66-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic [DataW-1:0] mag32(input logic [DataW-1:0] v);
    return v[DataW-1] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [DataW-1:0] sat32(input logic signed [65:0] v);
    if ((&v[65:DataW-1]) || !(|v[65:DataW-1])) begin
      return v[DataW-1:0];
    end
    return v[65] ? 32'h8000_0000 : 32'h7FFF_FFFF;
  endfunction

endpackage

@@ rtl/core/pdl_sqrt.sv @@
// Pipelined floor square root, one result bit per stage.
module pdl_sqrt import pdl_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SqW-1:0]   rad_i,
  input  logic [SideW-1:0] side_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output logic [SideW-1:0] side_o
);

  logic [RootW-1:0] vld_q;
  logic [SqW-1:0]   rem_q   [RootW];
  logic [RootW-1:0] root_q  [RootW];
  logic [SideW-1:0] side_q  [RootW];
  logic [SqW-1:0]   rem_src [RootW];
  logic [RootW-1:0] root_src[RootW];
  logic [SqW-1:0]   rem_d   [RootW];
  logic [RootW-1:0] root_d  [RootW];
  logic [SqW+1:0]   trial   [RootW];
  logic [RootW-1:0] ge;

  always_comb begin
    rem_src[0]  = rad_i;
    root_src[0] = '0;
    for (int s = 1; s < RootW; s++) begin
      rem_src[s]  = rem_q[s-1];
      root_src[s] = root_q[s-1];
    end
    for (int s = 0; s < RootW; s++) begin
      // (q + 2^k)^2 - q^2 = q*2^(k+1) + 2^(2k)
      trial[s] = ({{(SqW+2-RootW){1'b0}}, root_src[s]} << (RootW - s)) +
                 ((SqW+2)'(1) << (2 * (RootW - 1 - s)));
      ge[s]     = {2'b00, rem_src[s]} >= trial[s];
      rem_d[s]  = ge[s] ? rem_src[s] - trial[s][SqW-1:0] : rem_src[s];
      root_d[s] = root_src[s] | (RootW'(ge[s]) << (RootW - 1 - s));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[RootW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < RootW; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < RootW; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
      end
    end
  end

  assign valid_o = vld_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign side_o  = side_q[RootW-1];

endmodule

@@ rtl/core/pdl_scale.sv @@
// Three-lane pipelined restoring divider, one quotient bit per stage.
module pdl_scale import pdl_pkg::*; #(
  parameter int unsigned SideW = 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [2:0][NumW-1:0]       num_i,
  input  logic [RootW-1:0]           den_i,
  input  logic [SideW-1:0]           side_i,
  output logic                       valid_o,
  output logic [2:0][QuotW-1:0]      quot_o,
  output logic [SideW-1:0]           side_o
);

  logic [QuotW-1:0]          vld_q;
  logic [2:0][NumW-1:0]      rem_q   [QuotW];
  logic [2:0][QuotW-1:0]     quot_q  [QuotW];
  logic [RootW-1:0]          den_q   [QuotW];
  logic [SideW-1:0]          side_q  [QuotW];
  logic [2:0][NumW-1:0]      rem_src [QuotW];
  logic [2:0][QuotW-1:0]     quot_src[QuotW];
  logic [RootW-1:0]          den_src [QuotW];
  logic [2:0][NumW-1:0]      rem_d   [QuotW];
  logic [2:0][QuotW-1:0]     quot_d  [QuotW];
  logic [NumW:0]             dsh     [QuotW];
  logic [QuotW-1:0][2:0]     ge;

  always_comb begin
    rem_src[0]  = num_i;
    quot_src[0] = '0;
    den_src[0]  = den_i;
    for (int s = 1; s < QuotW; s++) begin
      rem_src[s]  = rem_q[s-1];
      quot_src[s] = quot_q[s-1];
      den_src[s]  = den_q[s-1];
    end
    for (int s = 0; s < QuotW; s++) begin
      dsh[s] = {{(NumW+1-RootW){1'b0}}, den_src[s]} << (QuotW - 1 - s);
      for (int l = 0; l < 3; l++) begin
        ge[s][l]     = {1'b0, rem_src[s][l]} >= dsh[s];
        rem_d[s][l]  = ge[s][l] ? rem_src[s][l] - dsh[s][NumW-1:0] : rem_src[s][l];
        quot_d[s][l] = quot_src[s][l] | (QuotW'(ge[s][l]) << (QuotW - 1 - s));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QuotW-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      for (int s = 1; s < QuotW; s++) begin
        side_q[s] <= side_q[s-1];
      end
      for (int s = 0; s < QuotW; s++) begin
        rem_q[s]  <= rem_d[s];
        quot_q[s] <= quot_d[s];
        den_q[s]  <= den_src[s];
      end
    end
  end

  assign valid_o = vld_q[QuotW-1];
  assign quot_o  = quot_q[QuotW-1];
  assign side_o  = side_q[QuotW-1];

endmodule

@@ rtl/core/haptic_position_pd_with_limits_top.sv @@
// Path: S1-S3, target sqrt and divider, S4-S8, force sqrt and divider, output register
//   (the two 32-stage square roots and two 31-stage dividers make up most of the stages).
// Throughput: one word per cycle; a stall on the output freezes the whole pipe.
// Reset: asynchronous, active low; clears all valid bits and sets every
//   configuration register to zero.
module haptic_position_pd_with_limits_top import pdl_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pdl_in_t            in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pdl_out_t           out_word_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [DataW-1:0]   cfg_data_i
);

  // Rounding half-LSB for gain products and the in-position threshold
  // ceil(2^(2F) / 250000), i.e. (0.002 m)^2 in raw squared units.
  localparam logic [63:0] RndHalf   = 64'd1 << (FRAC_BITS - 1);
  localparam logic [63:0] InPosThr  = ((64'd1 << (2 * FRAC_BITS)) + 64'd249999) / 64'd250000;

  // ---------------------------------------------------------------- config
  logic [DataW-1:0]      kp_q, kv_q;
  logic [QuotW-1:0]      flim_q, rad_q;
  logic                  wen_q;
  logic [2:0][DataW-1:0] home_q;
  logic [NumW-1:0]       rad2_q, flim2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q    <= '0;
      kv_q    <= '0;
      flim_q  <= '0;
      rad_q   <= '0;
      wen_q   <= 1'b0;
      home_q  <= '0;
      rad2_q  <= '0;
      flim2_q <= '0;
    end else begin
      // squared norm-test limits; user must move config only while idle, not enforced
      rad2_q  <= NumW'(64'(rad_q) * 64'(rad_q));
      flim2_q <= NumW'(64'(flim_q) * 64'(flim_q));
      if (cfg_valid_i) begin
        case (pdl_cfg_idx_e'(cfg_index_i))
          CfgPosGain:    kp_q      <= cfg_data_i;
          CfgVelGain:    kv_q      <= cfg_data_i;
          CfgForceLimit: flim_q    <= cfg_data_i[QuotW-1:0];
          CfgRadius:     rad_q     <= cfg_data_i[QuotW-1:0];
          CfgEnable:     wen_q     <= cfg_data_i[0];
          CfgHomeX:      home_q[0] <= cfg_data_i;
          CfgHomeY:      home_q[1] <= cfg_data_i;
          CfgHomeZ:      home_q[2] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // ------------------------------------------------------- pipeline control
  // One enable for every stage: the pipe moves unless the output word is
  // held by the consumer.
  logic en;
  logic out_valid_q;

  assign en          = !(out_valid_q && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = out_valid_q;

  logic [2:0][DataW-1:0] in_pos, in_vel, in_tgt;
  assign in_pos = {in_word_i.pos_z, in_word_i.pos_y, in_word_i.pos_x};
  assign in_vel = {in_word_i.vel_z, in_word_i.vel_y, in_word_i.vel_x};
  assign in_tgt = {in_word_i.target_z, in_word_i.target_y, in_word_i.target_x};

  // -------------------------------------------- S1: target offset from home
  logic                  s1_v_q;
  logic [2:0][DataW-1:0] s1_pos_q, s1_vel_q, s1_tgt_q, s1_rel_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pos_q <= in_pos;
      s1_vel_q <= in_vel;
      s1_tgt_q <= in_tgt;
      for (int i = 0; i < 3; i++) begin
        s1_rel_q[i] <= sat32(sx66(in_tgt[i]) - sx66(home_q[i]));
      end
    end
  end

  // ------------------------------- S2: offset squares, |rel| * radius
  logic                  s2_v_q;
  logic [2:0][SqW-1:0]   s2_sq_q;
  logic [2:0][NumW-1:0]  s2_num_q;
  logic [2:0]            s2_neg_q;
  logic [2:0][DataW-1:0] s2_pos_q, s2_vel_q, s2_tgt_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_pos_q <= s1_pos_q;
      s2_vel_q <= s1_vel_q;
      s2_tgt_q <= s1_tgt_q;
      for (int i = 0; i < 3; i++) begin
        s2_sq_q[i]  <= 64'(mag32(s1_rel_q[i])) * 64'(mag32(s1_rel_q[i]));
        s2_num_q[i] <= NumW'(64'(mag32(s1_rel_q[i])) * 64'(rad_q));
        s2_neg_q[i] <= s1_rel_q[i][DataW-1];
      end
    end
  end

  // ---------------------------------------- S3: norm^2 and sphere test
  typedef struct packed {
    logic [2:0][NumW-1:0]  num;
    logic [2:0]            neg;
    logic                  clip;
    logic [2:0][DataW-1:0] pos;
    logic [2:0][DataW-1:0] vel;
    logic [2:0][DataW-1:0] tgt;
  } tsq_side_t;

  typedef struct packed {
    logic [2:0]            neg;
    logic                  clip;
    logic [2:0][DataW-1:0] pos;
    logic [2:0][DataW-1:0] vel;
    logic [2:0][DataW-1:0] tgt;
  } tdiv_side_t;

  logic       s3_v_q;
  logic [SqW-1:0] s3_n2_q;
  tsq_side_t  s3_side_q;
  logic [SqW-1:0] s2_n2;

  assign s2_n2 = s2_sq_q[0] + s2_sq_q[1] + s2_sq_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_n2_q        <= s2_n2;
      s3_side_q.num  <= s2_num_q;
      s3_side_q.neg  <= s2_neg_q;
      s3_side_q.clip <= wen_q && (s2_n2 > {2'b00, rad2_q});
      s3_side_q.pos  <= s2_pos_q;
      s3_side_q.vel  <= s2_vel_q;
      s3_side_q.tgt  <= s2_tgt_q;
    end
  end

  // --------------------------- target clamp: sqrt, then radius*rel/norm
  logic             t_root_v;
  logic [RootW-1:0] t_norm;
  tsq_side_t        t_root_side;
  tdiv_side_t       t_div_in, t_div_side;
  logic             t_div_v;
  logic [2:0][QuotW-1:0] t_quot;

  pdl_sqrt #(.SideW($bits(tsq_side_t))) u_tgt_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_v_q),
    .rad_i   (s3_n2_q),
    .side_i  (s3_side_q),
    .valid_o (t_root_v),
    .root_o  (t_norm),
    .side_o  (t_root_side)
  );

  assign t_div_in.neg  = t_root_side.neg;
  assign t_div_in.clip = t_root_side.clip;
  assign t_div_in.pos  = t_root_side.pos;
  assign t_div_in.vel  = t_root_side.vel;
  assign t_div_in.tgt  = t_root_side.tgt;

  pdl_scale #(.SideW($bits(tdiv_side_t))) u_tgt_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t_root_v),
    .num_i   (t_root_side.num),
    .den_i   (t_norm),
    .side_i  (t_div_in),
    .valid_o (t_div_v),
    .quot_o  (t_quot),
    .side_o  (t_div_side)
  );

  // ----------------------------------- S4: desired point, position error
  logic                  s4_v_q;
  logic [2:0][DataW-1:0] s4_err_q, s4_vel_q;
  logic                  s4_tclip_q;
  logic signed [65:0]    s4_sc  [3];
  logic signed [65:0]    s4_des [3];
  logic [2:0][DataW-1:0] s4_err;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_sc[i]  = t_div_side.neg[i] ? -66'({35'b0, t_quot[i]}) : 66'({35'b0, t_quot[i]});
      s4_des[i] = t_div_side.clip ? sx66(home_q[i]) + s4_sc[i] : sx66(t_div_side.tgt[i]);
      s4_err[i] = sat32(sx66(t_div_side.pos[i]) - s4_des[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_err_q   <= s4_err;
      s4_vel_q   <= t_div_side.vel;
      s4_tclip_q <= t_div_side.clip;
    end
  end

  // ----------------------------- S5: gain products and error squares
  logic                s5_v_q;
  logic [2:0][SqW-1:0] s5_pp_q, s5_pv_q, s5_e2_q;
  logic [2:0]          s5_pneg_q, s5_vneg_q;
  logic                s5_tclip_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_pp_q[i]   <= 64'(kp_q) * 64'(mag32(s4_err_q[i]));
        s5_pv_q[i]   <= 64'(kv_q) * 64'(mag32(s4_vel_q[i]));
        s5_e2_q[i]   <= 64'(mag32(s4_err_q[i])) * 64'(mag32(s4_err_q[i]));
        s5_pneg_q[i] <= s4_err_q[i][DataW-1];
        s5_vneg_q[i] <= s4_vel_q[i][DataW-1];
      end
      s5_tclip_q <= s4_tclip_q;
    end
  end

  // ------------------------- S6: round, sum, saturate; in-position test
  logic                  s6_v_q;
  logic [2:0][DataW-1:0] s6_f_q;
  logic                  s6_inpos_q, s6_tclip_q;
  logic [63:0]           s6_rp [3];
  logic [63:0]           s6_rv [3];
  logic signed [65:0]    s6_tp [3];
  logic signed [65:0]    s6_tv [3];
  logic [2:0][DataW-1:0] s6_f;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s6_rp[i] = (s5_pp_q[i] + RndHalf) >> FRAC_BITS;
      s6_rv[i] = (s5_pv_q[i] + RndHalf) >> FRAC_BITS;
      s6_tp[i] = s5_pneg_q[i] ? -66'({2'b00, s6_rp[i]}) : 66'({2'b00, s6_rp[i]});
      s6_tv[i] = s5_vneg_q[i] ? -66'({2'b00, s6_rv[i]}) : 66'({2'b00, s6_rv[i]});
      s6_f[i]  = sat32(-s6_tp[i] - s6_tv[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s6_f_q     <= s6_f;
      s6_inpos_q <= (s5_e2_q[0] + s5_e2_q[1] + s5_e2_q[2]) < InPosThr;
      s6_tclip_q <= s5_tclip_q;
    end
  end

  // ----------------------------- S7: force squares, |f| * force limit
  logic                  s7_v_q;
  logic [2:0][SqW-1:0]   s7_f2_q;
  logic [2:0][NumW-1:0]  s7_fnum_q;
  logic [2:0][DataW-1:0] s7_f_q;
  logic                  s7_inpos_q, s7_tclip_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s7_f2_q[i]   <= 64'(mag32(s6_f_q[i])) * 64'(mag32(s6_f_q[i]));
        s7_fnum_q[i] <= NumW'(64'(mag32(s6_f_q[i])) * 64'(flim_q));
      end
      s7_f_q     <= s6_f_q;
      s7_inpos_q <= s6_inpos_q;
      s7_tclip_q <= s6_tclip_q;
    end
  end

  // ----------------------------------------- S8: force norm^2 and test
  typedef struct packed {
    logic [2:0][NumW-1:0]  num;
    logic [2:0][DataW-1:0] f;
    logic                  fclip;
    logic                  inpos;
    logic                  tclip;
  } fsq_side_t;

  typedef struct packed {
    logic [2:0][DataW-1:0] f;
    logic                  fclip;
    logic                  inpos;
    logic                  tclip;
  } fdiv_side_t;

  logic           s8_v_q;
  logic [SqW-1:0] s8_n2_q;
  fsq_side_t      s8_side_q;
  logic [SqW-1:0] s7_n2;

  assign s7_n2 = s7_f2_q[0] + s7_f2_q[1] + s7_f2_q[2];

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_n2_q         <= s7_n2;
      s8_side_q.num   <= s7_fnum_q;
      s8_side_q.f     <= s7_f_q;
      s8_side_q.fclip <= s7_n2 > {2'b00, flim2_q};
      s8_side_q.inpos <= s7_inpos_q;
      s8_side_q.tclip <= s7_tclip_q;
    end
  end

  // ------------------------- force clamp: sqrt, then limit*f/norm
  logic             f_root_v;
  logic [RootW-1:0] f_norm;
  fsq_side_t        f_root_side;
  fdiv_side_t       f_div_in, f_div_side;
  logic             f_div_v;
  logic [2:0][QuotW-1:0] f_quot;

  pdl_sqrt #(.SideW($bits(fsq_side_t))) u_frc_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s8_v_q),
    .rad_i   (s8_n2_q),
    .side_i  (s8_side_q),
    .valid_o (f_root_v),
    .root_o  (f_norm),
    .side_o  (f_root_side)
  );

  assign f_div_in.f     = f_root_side.f;
  assign f_div_in.fclip = f_root_side.fclip;
  assign f_div_in.inpos = f_root_side.inpos;
  assign f_div_in.tclip = f_root_side.tclip;

  pdl_scale #(.SideW($bits(fdiv_side_t))) u_frc_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_root_v),
    .num_i   (f_root_side.num),
    .den_i   (f_norm),
    .side_i  (f_div_in),
    .valid_o (f_div_v),
    .quot_o  (f_quot),
    .side_o  (f_div_side)
  );

  // ------------------------------------------------- output word register
  pdl_out_t              out_q;
  logic [2:0][DataW-1:0] fo;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (f_div_side.fclip) begin
        fo[i] = f_div_side.f[i][DataW-1] ? -{1'b0, f_quot[i]} : {1'b0, f_quot[i]};
      end else begin
        fo[i] = f_div_side.f[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.force_x        <= fo[0];
      out_q.force_y        <= fo[1];
      out_q.force_z        <= fo[2];
      out_q.in_position    <= f_div_side.inpos;
      out_q.force_clipped  <= f_div_side.fclip;
      out_q.target_clipped <= f_div_side.tclip;
    end
  end

  assign out_word_o = out_q;

  // valid bits of the local stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      s3_v_q      <= 1'b0;
      s4_v_q      <= 1'b0;
      s5_v_q      <= 1'b0;
      s6_v_q      <= 1'b0;
      s7_v_q      <= 1'b0;
      s8_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_v_q      <= in_valid_i;
      s2_v_q      <= s1_v_q;
      s3_v_q      <= s2_v_q;
      s4_v_q      <= t_div_v;
      s5_v_q      <= s4_v_q;
      s6_v_q      <= s5_v_q;
      s7_v_q      <= s6_v_q;
      s8_v_q      <= s7_v_q;
      out_valid_q <= f_div_v;
    end
  end

endmodule
